// File: hw/rtl/skein512_hash_engine_assert.svh
// Assertion macros for the Skein-512 engine checker.
`ifndef SKEIN512_HASH_ENGINE_ASSERT_SVH
`define SKEIN512_HASH_ENGINE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SKN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define SKN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/skn_pkg.sv
`default_nettype none
package skn_pkg;
  localparam logic [63:0] KsParity = 64'h1BD11BDAA9FC1A22;
  localparam logic [63:0] CfgWord0 = 64'h0000000133414853;
  localparam logic [5:0]  TypeCfg  = 6'd4;
  localparam logic [5:0]  TypeMsg  = 6'd48;
  localparam logic [5:0]  TypeOut  = 6'd63;
  localparam int unsigned Rounds   = 72;

  // Queue entry from front to back.
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } skn_req_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CFG, ST_BYTE, ST_FIN, ST_OUT, ST_EMIT, ST_RUN
  } skn_state_e;

  function automatic logic [5:0] rot_amt(input logic [2:0] r, input logic [1:0] i);
    logic [5:0] t [8][4];
    t[0] = '{6'd46, 6'd36, 6'd19, 6'd37};
    t[1] = '{6'd33, 6'd27, 6'd14, 6'd42};
    t[2] = '{6'd17, 6'd49, 6'd36, 6'd39};
    t[3] = '{6'd44, 6'd9,  6'd54, 6'd56};
    t[4] = '{6'd39, 6'd30, 6'd34, 6'd24};
    t[5] = '{6'd13, 6'd50, 6'd10, 6'd17};
    t[6] = '{6'd25, 6'd29, 6'd39, 6'd43};
    t[7] = '{6'd8,  6'd35, 6'd56, 6'd22};
    return t[r][i];
  endfunction

  function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] n);
    return (x << n) | (x >> (7'd64 - {1'b0, n}));
  endfunction
endpackage
`default_nettype wire

// File: hw/rtl/skn_front.sv
`default_nettype none
// Input side: two-entry request queue, clamps byte counts.
module skn_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [63:0]   msg_word_i,
  input  wire logic [3:0]    word_bytes_i,
  input  wire logic          msg_last_i,
  output logic               req_valid_o,
  output skn_pkg::skn_req_t  req_o,
  input  wire logic          req_take_i
);
  import skn_pkg::*;
  skn_req_t   mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  skn_req_t   in_req;
  logic       wr, rd;

  always_comb begin
    in_req.word   = msg_word_i;
    in_req.nbytes = (word_bytes_i > 4'd8) ? 4'd8 : word_bytes_i;
    in_req.last   = msg_last_i;
  end
  assign full        = cnt_q[1];
  assign wr          = push && !full;
  assign req_valid_o = cnt_q != 2'd0;
  assign rd          = req_take_i && req_valid_o;
  assign req_o       = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      mem_q[wp_q] <= in_req;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/skn_threefish.sv
`default_nettype none
// Iterative Threefish-512 UBI: four rounds plus subkey add per cycle.
module skn_threefish (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic [511:0] key_i,
  input  wire logic [511:0] pt_i,
  input  wire logic [63:0]  t0_i,
  input  wire logic [63:0]  t1_i,
  output logic              done_o,
  output logic [511:0]      cv_o
);
  import skn_pkg::*;
  logic [63:0] k_q [9];
  logic [63:0] tw_q [3];
  logic [63:0] v_q [8];
  logic [63:0] p_q [8];
  logic [4:0]  s_q;
  logic [3:0]  k9_q;
  logic [1:0]  t3_q;
  logic        busy_q;
  logic [63:0] v_d [8];
  logic [63:0] a [8];
  logic [63:0] b [8];
  logic [63:0] kx;
  logic [4:0]  sn;
  logic [3:0]  sn9;
  logic [1:0]  sn3;
  logic [4:0]  kraw;
  logic [3:0]  ki;
  logic [1:0]  ti;

  always_comb begin
    kx = KsParity;
    for (int i = 0; i < 8; i++) kx = kx ^ key_i[64*i +: 64];
  end

  // Four rounds then key injection s+1. Subkey and tweak indexes run as
  // wrapping mod-9 and mod-3 counters.
  always_comb begin
    a = v_q;
    for (int d = 0; d < 4; d++) begin
      for (int i = 0; i < 4; i++) begin
        b[2*i]   = a[2*i] + a[2*i+1];
        b[2*i+1] = rotl(a[2*i+1], rot_amt({s_q[0], 2'(d)}, 2'(i))) ^ b[2*i];
      end
      a[2] = b[0]; a[1] = b[1]; a[4] = b[2]; a[7] = b[3];
      a[6] = b[4]; a[5] = b[5]; a[0] = b[6]; a[3] = b[7];
    end
    sn  = s_q + 5'd1;
    sn9 = (k9_q == 4'd8) ? 4'd0 : k9_q + 4'd1;
    sn3 = (t3_q == 2'd2) ? 2'd0 : t3_q + 2'd1;
    for (int i = 0; i < 8; i++) begin
      kraw = {1'b0, sn9} + 5'(i);
      ki = (kraw >= 5'd9) ? 4'(kraw - 5'd9) : kraw[3:0];
      v_d[i] = a[i] + k_q[ki];
    end
    ti = sn3;
    v_d[5] = v_d[5] + tw_q[ti];
    ti = (sn3 == 2'd2) ? 2'd0 : sn3 + 2'd1;
    v_d[6] = v_d[6] + tw_q[ti];
    v_d[7] = v_d[7] + 64'(sn);
  end

  assign done_o = busy_q && s_q == 5'(Rounds / 4 - 1);
  always_comb begin
    for (int i = 0; i < 8; i++) cv_o[64*i +: 64] = v_d[i] ^ p_q[i];
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 8; i++) begin
        k_q[i] <= key_i[64*i +: 64];
        p_q[i] <= pt_i[64*i +: 64];
        v_q[i] <= pt_i[64*i +: 64] + key_i[64*i +: 64]
                  + ((i == 5) ? t0_i : (i == 6) ? t1_i : 64'd0);
      end
      k_q[8] <= kx;
      tw_q[0] <= t0_i; tw_q[1] <= t1_i; tw_q[2] <= t0_i ^ t1_i;
    end else if (busy_q) begin
      v_q <= v_d;
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; s_q <= 5'd0; k9_q <= 4'd0; t3_q <= 2'd0;
    end else if (start_i) begin
      busy_q <= 1'b1; s_q <= 5'd0; k9_q <= 4'd0; t3_q <= 2'd0;
    end else if (busy_q) begin
      s_q <= sn; k9_q <= sn9; t3_q <= sn3;
      if (done_o) busy_q <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/skn_back.sv
`default_nettype none
// Back end: message buffering, UBI sequencing and hash word output queue.
module skn_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [9:0]    hash_bits_i,
  input  wire logic          req_valid_i,
  input  skn_pkg::skn_req_t  req_i,
  output logic               req_take_o,
  output logic               empty,
  input  wire logic          pop,
  output logic [63:0]        hash_word_o,
  output logic [3:0]         hash_bytes_o,
  output logic               hash_last_o
);
  import skn_pkg::*;
  skn_state_e st_q, st_d;
  skn_state_e ret_q;
  logic [511:0] cv_q, buf_q;
  logic [6:0]   fill_q;
  logic [63:0]  pos_q;
  logic         first_q, started_q;
  logic [9:0]   bits_q;
  logic [3:0]   bi_q;
  skn_req_t     cur_q;
  logic [63:0]  ow_q [8];
  logic [3:0]   ocnt_q, orp_q, nwords_q;
  logic [6:0]   nbytes_q;

  logic         tf_start, tf_done;
  logic [511:0] tf_key, tf_pt, tf_cv;
  logic [63:0]  tf_t0, tf_t1;
  logic [9:0]   eff_bits;
  logic [6:0]   nbytes_c;

  skn_threefish u_tf (
    .clk_i, .rst_ni, .start_i(tf_start), .key_i(tf_key), .pt_i(tf_pt),
    .t0_i(tf_t0), .t1_i(tf_t1), .done_o(tf_done), .cv_o(tf_cv)
  );

  assign eff_bits = (hash_bits_i == 10'd0) ? 10'd1 :
                    (hash_bits_i > 10'd512) ? 10'd512 : hash_bits_i;
  assign nbytes_c = 7'((11'(bits_q) + 11'd7) >> 3);

  always_comb begin
    st_d = st_q; tf_start = 1'b0; req_take_o = 1'b0;
    tf_key = cv_q; tf_pt = buf_q;
    tf_t0 = pos_q + 64'(fill_q);
    tf_t1 = {1'b0, first_q, TypeMsg, 56'd0};
    case (st_q)
      ST_IDLE: begin
        if (req_valid_i && ocnt_q == 4'd0) begin
          req_take_o = 1'b1;
          if (!started_q) begin
            tf_start = 1'b1; tf_key = '0;
            tf_pt = {384'd0, 54'd0, eff_bits, CfgWord0};
            tf_t0 = 64'd32; tf_t1 = {2'b11, TypeCfg, 56'd0};
            st_d = ST_RUN;
          end else begin
            st_d = ST_BYTE;
          end
        end
      end
      ST_BYTE: begin
        if (bi_q == cur_q.nbytes) begin
          st_d = cur_q.last ? ST_FIN : ST_IDLE;
        end else if (fill_q == 7'd64) begin
          tf_start = 1'b1; st_d = ST_RUN;
        end
      end
      ST_FIN: begin
        tf_start = 1'b1;
        tf_t1 = {1'b1, first_q, TypeMsg, 56'd0};
        st_d = ST_RUN;
      end
      ST_OUT: begin
        tf_start = 1'b1; tf_pt = '0; tf_t0 = 64'd8;
        tf_t1 = {2'b11, TypeOut, 56'd0};
        st_d = ST_RUN;
      end
      ST_RUN: begin
        if (tf_done) st_d = ret_q;
      end
      ST_EMIT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  assign empty        = ocnt_q == 4'd0;
  assign hash_word_o  = ow_q[orp_q[2:0]];
  assign hash_last_o  = (orp_q + 4'd1) == nwords_q;
  assign hash_bytes_o = hash_last_o ? 4'(nbytes_q - {orp_q[2:0], 3'b000}) : 4'd8;

  always_ff @(posedge clk_i) begin
    if (st_q == ST_IDLE && req_take_o) cur_q <= req_i;
    if (st_q == ST_RUN && tf_done && ret_q == ST_EMIT) begin
      for (int i = 0; i < 8; i++) ow_q[i] <= tf_cv[64*i +: 64];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; ret_q <= ST_IDLE; cv_q <= '0; buf_q <= '0;
      fill_q <= 7'd0; pos_q <= 64'd0; first_q <= 1'b1; started_q <= 1'b0;
      bits_q <= 10'd512; bi_q <= 4'd0; ocnt_q <= 4'd0; orp_q <= 4'd0;
      nwords_q <= 4'd8; nbytes_q <= 7'd64;
    end else begin
      st_q <= st_d;
      case (st_q)
        ST_IDLE: begin
          bi_q <= 4'd0;
          if (req_take_o && !started_q) begin
            bits_q <= eff_bits; ret_q <= ST_BYTE; started_q <= 1'b1;
          end
        end
        ST_BYTE: begin
          if (bi_q != cur_q.nbytes && fill_q == 7'd64) begin
            ret_q <= ST_BYTE;
          end else if (bi_q != cur_q.nbytes) begin
            buf_q[{fill_q[5:0], 3'b000} +: 8] <= cur_q.word[{bi_q[2:0], 3'b000} +: 8];
            fill_q <= fill_q + 7'd1; bi_q <= bi_q + 4'd1;
          end
        end
        ST_FIN: ret_q <= ST_OUT;
        ST_OUT: ret_q <= ST_EMIT;
        ST_RUN: begin
          if (tf_done) begin
            case (ret_q)
              ST_BYTE: begin
                if (fill_q == 7'd64) begin
                  cv_q <= tf_cv; pos_q <= pos_q + 64'd64; first_q <= 1'b0;
                  buf_q <= '0; fill_q <= 7'd0;
                end else begin
                  cv_q <= tf_cv; pos_q <= 64'd0; first_q <= 1'b1;
                  buf_q <= '0; fill_q <= 7'd0;
                end
              end
              ST_OUT: begin
                cv_q <= tf_cv; buf_q <= '0; fill_q <= 7'd0;
              end
              ST_EMIT: begin
                nbytes_q <= nbytes_c;
                nwords_q <= 4'((8'(nbytes_c) + 8'd7) >> 3);
                ocnt_q <= 4'((8'(nbytes_c) + 8'd7) >> 3);
                orp_q <= 4'd0; started_q <= 1'b0;
                pos_q <= 64'd0; first_q <= 1'b1;
              end
              default: ;
            endcase
          end
        end
        default: ;
      endcase
      if (pop && !empty) begin
        ocnt_q <= ocnt_q - 4'd1; orp_q <= orp_q + 4'd1;
      end
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/skein512_hash_engine.sv
`default_nettype none
// Channel  | Handshake          | Payload
// request  | push / full        | msg_word_i, word_bytes_i, msg_last_i
// result   | pop / empty        | hash_word_o, hash_bytes_o, hash_last_o
// config   | hash_bits_we_i     | hash_bits_i
// Each request's bytes are packed into the block buffer in the byte loop; every
// full 64-byte block goes through the Threefish unit (four rounds per cycle).
// A new message first runs the config UBI; the last word adds two
// more UBI passes, then ceil(bits/64) hash words wait in the output queue.
// A two-entry request queue decouples intake; the back end waits for the
// output queue to drain before starting the next request.
// Asynchronous active-low reset; hash length resets to 512 bits.
module skein512_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [63:0] msg_word_i,
  input  wire logic [3:0]  word_bytes_i,
  input  wire logic        msg_last_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      hash_word_o,
  output logic [3:0]       hash_bytes_o,
  output logic             hash_last_o,
  input  wire logic        hash_bits_we_i,
  input  wire logic [9:0]  hash_bits_i
);
  import skn_pkg::*;
  logic [9:0] bits_q;
  logic       rv, take;
  skn_req_t   req;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= 10'd512;
    end else if (hash_bits_we_i) begin
      bits_q <= hash_bits_i;
    end
  end

  skn_front u_front (
    .clk_i, .rst_ni, .push(push), .full(full), .msg_word_i, .word_bytes_i,
    .msg_last_i, .req_valid_o(rv), .req_o(req), .req_take_i(take)
  );
  skn_back u_back (
    .clk_i, .rst_ni, .hash_bits_i(bits_q), .req_valid_i(rv), .req_i(req),
    .req_take_o(take), .empty(empty), .pop(pop), .hash_word_o,
    .hash_bytes_o, .hash_last_o
  );
endmodule
`default_nettype wire

// File: hw/rtl/skn_checker.sv
`default_nettype none
`include "skein512_hash_engine_assert.svh"
module skn_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [3:0] hash_bytes_o,
  input wire logic       hash_last_o
);
  `SKN_ASSERT_IMP(a_bytes_rng, clk_i, rst_ni, !empty, hash_bytes_o != 4'd0 && hash_bytes_o <= 4'd8)
  `SKN_ASSERT_IMP(a_full_word, clk_i, rst_ni, !empty && !hash_last_o, hash_bytes_o == 4'd8)
  `SKN_ASSERT_NXT(a_more_follow, clk_i, rst_ni, !empty && pop && !hash_last_o, !empty)
endmodule
bind skein512_hash_engine skn_checker u_chk (
  .clk_i, .rst_ni, .empty, .pop, .hash_bytes_o, .hash_last_o
);
`default_nettype wire
